>>> src/tcce_pkg.sv
package tcce_pkg;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_CALC,
    ST_SCROLL,
    ST_DONE
  } state_t;

  // Control flags from the put-character unit to the sequencer.
  typedef struct packed {
    logic wr_en;
    logic scroll;
  } put_ctl_t;

  localparam logic [7:0]  CH_BACKSPACE = 8'd8;
  localparam logic [7:0]  CH_TAB       = 8'd9;
  localparam logic [7:0]  CH_NEWLINE   = 8'd10;
  localparam logic [7:0]  CH_RETURN    = 8'd13;
  localparam logic [7:0]  CH_SPACE     = 8'h20;
  localparam logic [3:0]  BLANK_FG     = 4'h7;
  localparam logic [15:0] RESET_CELL   = 16'h0720;

endpackage

>>> src/tcce_cell_ram.sv
module tcce_cell_ram #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/tcce_put_unit.sv
module tcce_put_unit #(
  parameter int ROWS      = 25,
  parameter int COLS      = 80,
  parameter int TAB_WIDTH = 8,
  parameter int ROW_W     = 5,
  parameter int COL_W     = 7,
  parameter int Q_W       = 4
) (
  input  logic [ROW_W-1:0]  row_i,
  input  logic [COL_W-1:0]  col_i,
  input  logic [Q_W-1:0]    tab_q_i,
  input  logic [7:0]        char_i,
  output logic [ROW_W-1:0]  row_o,
  output logic [COL_W-1:0]  col_o,
  output logic [COL_W-1:0]  wr_col_o,
  output logic [7:0]        wr_char_o,
  output tcce_pkg::put_ctl_t ctl_o
);

  localparam int STOP_W = $clog2(COLS + TAB_WIDTH);

  logic [ROW_W:0]    row_inc;
  logic [COL_W:0]    col_inc;
  logic [STOP_W-1:0] stop;
  logic [ROW_W:0]    row_nx;

  assign row_inc = {1'b0, row_i} + (ROW_W+1)'(1);
  assign col_inc = {1'b0, col_i} + (COL_W+1)'(1);
  // Next tab stop from the registered quotient of the column.
  assign stop    = (STOP_W'(tab_q_i) + STOP_W'(1)) * STOP_W'(TAB_WIDTH);

  always_comb begin
    row_nx       = {1'b0, row_i};
    col_o        = col_i;
    wr_col_o     = col_i;
    wr_char_o    = char_i;
    ctl_o.wr_en  = 1'b0;
    case (char_i)
      tcce_pkg::CH_NEWLINE: begin
        col_o  = '0;
        row_nx = row_inc;
      end
      tcce_pkg::CH_RETURN: begin
        col_o = '0;
      end
      tcce_pkg::CH_TAB: begin
        if (stop >= STOP_W'(COLS)) begin
          col_o  = '0;
          row_nx = row_inc;
        end else begin
          col_o = COL_W'(stop);
        end
      end
      tcce_pkg::CH_BACKSPACE: begin
        if (col_i != '0) begin
          col_o = col_i - COL_W'(1);
        end
        wr_col_o    = col_o;
        wr_char_o   = tcce_pkg::CH_SPACE;
        ctl_o.wr_en = 1'b1;
      end
      default: begin
        ctl_o.wr_en = 1'b1;
        if (col_inc >= (COL_W+1)'(COLS)) begin
          col_o  = '0;
          row_nx = row_inc;
        end else begin
          col_o = col_inc[COL_W-1:0];
        end
      end
    endcase
    ctl_o.scroll = (row_nx >= (ROW_W+1)'(ROWS));
    row_o = ctl_o.scroll ? ROW_W'(ROWS - 1) : row_nx[ROW_W-1:0];
  end

endmodule

>>> src/text_console_char_engine.sv
// Channel  Direction  Handshake               Payload
// in_      slave      in_tvalid / in_tready   in_tuser operation, in_tdata request fields
// out_     master     out_tvalid / out_tready out_tdata cursor and cell result
//
// Put character, set cursor and read cell pass through a decode state, which accesses the
// cell memory, and a done state, which loads the output register, and run back to back.
// A scroll adds a pass that copies each cell one row up, reading only the cells below the
// top row, and writes blanks to the bottom row; a clear adds a pass of fill writes. After
// reset a clearing pass writes the grey blank to every cell with in_tready low.
// A result that waits in the output register holds off the next request after decode.
module text_console_char_engine #(
  parameter int ROWS      = 25,
  parameter int COLS      = 80,
  parameter int TAB_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // operation
  input  logic [39:0] in_tdata,   // char_code, attribute, background, row_request,
                                  // col_request, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // cursor_row_out, cursor_col_out, cursor_linear,
                                  // cell_word, zero pad
);

  localparam int CELLS     = ROWS * COLS;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int COL_W     = $clog2(COLS);
  localparam int Q_W       = $clog2((COLS - 1) / TAB_WIDTH + 2);
  localparam int TAB_RECIP = (2**16 + TAB_WIDTH - 1) / TAB_WIDTH;
  localparam int PROD_W    = COL_W + 17;

  function automatic logic [7:0] clamp_req(logic [7:0] raw, logic [7:0] limit);
    logic [7:0] v;
    begin
      if (raw[7]) begin
        v = 8'd0;
      end else if (raw >= limit) begin
        v = limit - 8'd1;
      end else begin
        v = raw;
      end
      return v;
    end
  endfunction

  tcce_pkg::state_t state_r, state_nxt;
  logic [ADDR_W:0]  scan_r, scan_nxt;
  logic [15:0]      fill_word_r, fill_word_nxt;
  logic             init_r, init_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [Q_W-1:0]   tab_q_r;
  logic [PROD_W-1:0] tab_prod;

  tcce_pkg::op_t    op_r;
  logic [7:0]       ch_r, attr_r, rreq_r, creq_r;
  logic [3:0]       bg_r;

  logic             out_valid_r, out_valid_nxt;
  logic [4:0]       out_row_r;
  logic [6:0]       out_col_r;
  logic [10:0]      out_lin_r;
  logic [15:0]      out_cell_r;
  logic             out_load;
  logic             out_free;
  logic             in_accept;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [15:0]       wr_data, rd_data;

  logic [ROW_W-1:0]  put_row;
  logic [COL_W-1:0]  put_col, put_wr_col;
  logic [7:0]        put_char;
  tcce_pkg::put_ctl_t put_ctl;
  logic [ROW_W-1:0]  clamp_row;
  logic [COL_W-1:0]  clamp_col;
  logic [15:0]       lin_full;

  tcce_cell_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W),
    .DATA_W (16)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tcce_put_unit #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .TAB_WIDTH (TAB_WIDTH),
    .ROW_W     (ROW_W),
    .COL_W     (COL_W),
    .Q_W       (Q_W)
  ) u_put (
    .row_i     (row_r),
    .col_i     (col_r),
    .tab_q_i   (tab_q_r),
    .char_i    (ch_r),
    .row_o     (put_row),
    .col_o     (put_col),
    .wr_col_o  (put_wr_col),
    .wr_char_o (put_char),
    .ctl_o     (put_ctl)
  );

  assign clamp_row = ROW_W'(clamp_req(rreq_r, 8'(ROWS)));
  assign clamp_col = COL_W'(clamp_req(creq_r, 8'(COLS)));

  // Column divided by the tab width through a reciprocal; the registered quotient follows
  // the column in the next cycle, and the column never changes in the cycle before a decode.
  assign tab_prod = PROD_W'(col_r) * PROD_W'(TAB_RECIP);

  always_ff @(posedge clk) begin
    tab_q_r <= Q_W'(tab_prod >> 16);
  end

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == tcce_pkg::ST_IDLE) ||
                     (state_r == tcce_pkg::ST_DONE && out_free);
  assign in_accept = in_tvalid && in_tready;
  assign lin_full  = 16'(row_r) * 16'(COLS) + 16'(col_r);

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    fill_word_nxt = fill_word_r;
    init_nxt      = init_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = fill_word_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    out_load      = 1'b0;
    case (state_r)
      tcce_pkg::ST_FILL: begin
        wr_en    = 1'b1;
        wr_addr  = scan_r[ADDR_W-1:0];
        scan_nxt = scan_r + (ADDR_W+1)'(1);
        if (scan_r == (ADDR_W+1)'(CELLS - 1)) begin
          scan_nxt  = '0;
          init_nxt  = 1'b0;
          state_nxt = init_r ? tcce_pkg::ST_IDLE : tcce_pkg::ST_DONE;
        end
      end
      tcce_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_nxt = tcce_pkg::ST_CALC;
        end
      end
      tcce_pkg::ST_CALC: begin
        state_nxt = tcce_pkg::ST_DONE;
        case (op_r)
          tcce_pkg::OP_PUT: begin
            row_nxt = put_row;
            col_nxt = put_col;
            wr_en   = put_ctl.wr_en;
            wr_addr = ADDR_W'(row_r) * ADDR_W'(COLS) + ADDR_W'(put_wr_col);
            wr_data = {attr_r, put_char};
            if (put_ctl.scroll) begin
              scan_nxt  = '0;
              state_nxt = tcce_pkg::ST_SCROLL;
            end
          end
          tcce_pkg::OP_SET: begin
            row_nxt = clamp_row;
            col_nxt = clamp_col;
          end
          tcce_pkg::OP_CLEAR: begin
            row_nxt       = '0;
            col_nxt       = '0;
            scan_nxt      = '0;
            fill_word_nxt = {bg_r, tcce_pkg::BLANK_FG, tcce_pkg::CH_SPACE};
            state_nxt     = tcce_pkg::ST_FILL;
          end
          tcce_pkg::OP_READ: begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(clamp_row) * ADDR_W'(COLS) + ADDR_W'(clamp_col);
          end
          default: begin
            state_nxt = tcce_pkg::ST_DONE;
          end
        endcase
      end
      tcce_pkg::ST_SCROLL: begin
        // Read one row ahead; the cell read last cycle lands one row up. The bottom
        // row gets the blank in the same write slot.
        rd_en    = (scan_r < (ADDR_W+1)'(CELLS - COLS));
        rd_addr  = ADDR_W'(scan_r + (ADDR_W+1)'(COLS));
        wr_en    = (scan_r != '0);
        wr_addr  = ADDR_W'(scan_r - (ADDR_W+1)'(1));
        wr_data  = (scan_r <= (ADDR_W+1)'(CELLS - COLS)) ? rd_data
                                                         : {attr_r, tcce_pkg::CH_SPACE};
        scan_nxt = scan_r + (ADDR_W+1)'(1);
        if (scan_r == (ADDR_W+1)'(CELLS)) begin
          scan_nxt  = '0;
          state_nxt = tcce_pkg::ST_DONE;
        end
      end
      tcce_pkg::ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = in_accept ? tcce_pkg::ST_CALC : tcce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tcce_pkg::ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcce_pkg::ST_FILL;
      scan_r      <= '0;
      fill_word_r <= tcce_pkg::RESET_CELL;
      init_r      <= 1'b1;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      fill_word_r <= fill_word_nxt;
      init_r      <= init_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= tcce_pkg::op_t'(in_tuser);
      ch_r   <= in_tdata[7:0];
      attr_r <= in_tdata[15:8];
      bg_r   <= in_tdata[19:16];
      rreq_r <= in_tdata[27:20];
      creq_r <= in_tdata[35:28];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r  <= 5'(row_r);
      out_col_r  <= 7'(col_r);
      out_lin_r  <= lin_full[10:0];
      out_cell_r <= (op_r == tcce_pkg::OP_READ) ? rd_data : 16'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_cell_r, out_lin_r, out_col_r, out_row_r};

endmodule
